/* hw/rtl/refcounted_allocation_table_defines.svh */
// Assertion macros for the reference-counted allocation table.
`ifndef REFCOUNTED_ALLOCATION_TABLE_DEFINES_SVH
`define REFCOUNTED_ALLOCATION_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/rat_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the reference-counted allocation table.
package rat_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int POOL_W        = 8;
    localparam int ADDR_W        = 48;
    localparam int SIZE_W        = 48;
    localparam int REFS_W        = 16;

    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [REFS_W-1:0] REFS_MAX = '1;
    localparam logic [REFS_W-1:0] REFS_ONE = REFS_W'(1);

    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_GET     = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [POOL_W-1:0] pool;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic [REFS_W-1:0] refs;
    } row_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        row_t             wr_row;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [POOL_W-1:0] pool;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIZE_W-1:0] found_size;
        logic              global_flag;
        logic [REFS_W-1:0] ref_count;
    } result_t;

endpackage

/* hw/rtl/rat_mem.sv */
`timescale 1ns / 1ps
// Entry storage: one write port, one registered read port.
module rat_mem
(
    input  logic              clk,
    input  rat_pkg::mem_req_t req,
    output rat_pkg::row_t     rd_row
);

    rat_pkg::row_t mem_array [rat_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_row <= mem_array[req.rd_addr];
        end
    end

endmodule

/* hw/rtl/rat_seq.sv */
`timescale 1ns / 1ps
// Scan sequencer with the shared key comparator and the entry valid bits.
`include "refcounted_allocation_table_defines.svh"
module rat_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  rat_pkg::item_t      req_item,
    output logic                busy,
    input  logic                out_free,
    input  rat_pkg::row_t       rd_row,
    output rat_pkg::mem_req_t   mem_req,
    output logic                fin_fire,
    output rat_pkg::result_t    result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [rat_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [rat_pkg::IDX_W-1:0]         issue_idx_reg, issue_idx_next;
    logic                              issue_on_reg, issue_on_next;
    logic                              pend_reg, pend_next;
    logic [rat_pkg::IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                              hit_reg, hit_next;
    logic [rat_pkg::IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                              free_found_reg, free_found_next;
    logic [rat_pkg::IDX_W-1:0]         free_idx_reg, free_idx_next;
    rat_pkg::row_t                     hit_row_reg, hit_row_next;
    rat_pkg::item_t                    item_reg, item_next;
    logic                              hit_now;
    logic [rat_pkg::REFS_W-1:0]        refs_new;

    assign busy = (state_reg != S_IDLE);

    // single comparator: the row read last cycle against the request key
    assign hit_now = pend_reg && valid_reg[pend_idx_reg]
                     && (rd_row.pool == item_reg.pool)
                     && (rd_row.address == item_reg.address);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        issue_idx_next  = issue_idx_reg;
        issue_on_next   = issue_on_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_row_next    = hit_row_reg;
        item_next       = item_reg;
        refs_new        = '0;
        fin_fire        = 1'b0;
        result          = '0;
        result.status   = rat_pkg::ST_OK;

        mem_req         = '0;
        mem_req.rd_en   = (state_reg == S_SCAN) && issue_on_reg;
        mem_req.rd_addr = issue_idx_reg;
        mem_req.wr_addr = hit_idx_reg;
        mem_req.wr_row  = hit_row_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next       = req_item;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    pend_next       = 1'b0;
                    issue_idx_next  = '0;
                    if (req_item.action == rat_pkg::ACT_CLEAR)
                    begin
                        issue_on_next = 1'b0;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        issue_on_next = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                pend_next     = issue_on_reg;
                pend_idx_next = issue_idx_reg;
                if (issue_on_reg)
                begin
                    if (issue_idx_reg == rat_pkg::IDX_LAST)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                if (pend_reg && !valid_reg[pend_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                if (hit_now)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = pend_idx_reg;
                    hit_row_next  = rd_row;
                    issue_on_next = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = S_FINISH;
                end
                else if (pend_reg && (pend_idx_reg == rat_pkg::IDX_LAST))
                begin
                    pend_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    fin_fire   = 1'b1;
                    state_next = S_IDLE;
                    unique case (item_reg.action)
                        rat_pkg::ACT_CREATE:
                        begin
                            if (hit_reg)
                            begin
                                result.status = rat_pkg::ST_DUPLICATE;
                            end
                            else if (free_found_reg)
                            begin
                                mem_req.wr_en          = 1'b1;
                                mem_req.wr_addr        = free_idx_reg;
                                mem_req.wr_row.pool    = item_reg.pool;
                                mem_req.wr_row.address = item_reg.address;
                                mem_req.wr_row.size    = item_reg.size;
                                mem_req.wr_row.refs    = rat_pkg::REFS_ONE;
                                valid_next[free_idx_reg] = 1'b1;
                                result.global_flag     = 1'b1;
                                result.ref_count       = rat_pkg::REFS_ONE;
                            end
                            else
                            begin
                                result.status = rat_pkg::ST_FULL;
                            end
                        end
                        rat_pkg::ACT_GET:
                        begin
                            if (hit_reg)
                            begin
                                refs_new = (hit_row_reg.refs == rat_pkg::REFS_MAX)
                                           ? hit_row_reg.refs
                                           : hit_row_reg.refs + 1'b1;
                                mem_req.wr_en       = 1'b1;
                                mem_req.wr_row.refs = refs_new;
                                result.found_size   = hit_row_reg.size;
                                result.global_flag  = 1'b1;
                                result.ref_count    = refs_new;
                            end
                            else
                            begin
                                result.status = rat_pkg::ST_NOT_FOUND;
                            end
                        end
                        rat_pkg::ACT_RELEASE:
                        begin
                            if (hit_reg)
                            begin
                                if (hit_row_reg.refs <= rat_pkg::REFS_ONE)
                                begin
                                    valid_next[hit_idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    refs_new            = hit_row_reg.refs - 1'b1;
                                    mem_req.wr_en       = 1'b1;
                                    mem_req.wr_row.refs = refs_new;
                                    result.ref_count    = refs_new;
                                end
                            end
                            else
                            begin
                                result.status = rat_pkg::ST_NOT_FOUND;
                            end
                        end
                        rat_pkg::ACT_CLEAR:
                        begin
                            valid_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            issue_on_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issue_on_reg   <= issue_on_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        hit_row_reg   <= hit_row_next;
        item_reg      <= item_next;
    end

    `RAT_ASSERT_IMP(a_pend_in_scan, clk, rst_n, pend_reg, state_reg == S_SCAN, "compare outside scan")
    `RAT_ASSERT_IMP(a_hit_valid, clk, rst_n, (state_reg == S_FINISH) && hit_reg, valid_reg[hit_idx_reg], "hit on freed entry")
    `RAT_ASSERT_NXT(a_finish_hold, clk, rst_n, (state_reg == S_FINISH) && !out_free, state_reg == S_FINISH, "finish lost while output full")
    `RAT_ASSERT_NXT(a_create_sets, clk, rst_n, fin_fire && (item_reg.action == rat_pkg::ACT_CREATE) && !hit_reg && free_found_reg, valid_reg[$past(free_idx_reg)], "created entry not valid")

endmodule

/* hw/rtl/refcounted_allocation_table.sv */
`timescale 1ns / 1ps
// Top level of the reference-counted allocation table.
//
//  channel   handshake              fields
//  request   in_valid / in_stall    action, pool_id, address, alloc_size
//  result    out_valid / out_stall  status, found_size, global_flag, ref_count
//
// Create, get and release scan the entries one per cycle through the single read port and
// key comparator and stop at the first entry that matches the key; clear skips the scan.
// The next request is taken when the sequencer is back in idle after the result is produced.
// Reset empties the table at once through the valid bits.
// A request is taken whenever the sequencer is idle, even with a result still waiting;
// a finished request holds in its last step while the result register is stalled.
module refcounted_allocation_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [rat_pkg::POOL_W-1:0]    pool_id,
    input  logic [rat_pkg::ADDR_W-1:0]    address,
    input  logic [rat_pkg::SIZE_W-1:0]    alloc_size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [rat_pkg::SIZE_W-1:0]    found_size,
    output logic                          global_flag,
    output logic [rat_pkg::REFS_W-1:0]    ref_count
);

    rat_pkg::item_t    req_item;
    rat_pkg::mem_req_t mem_req;
    rat_pkg::row_t     rd_row;
    rat_pkg::result_t  result;
    rat_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              fin_fire;
    logic              busy;

    assign req_item.action  = action;
    assign req_item.pool    = pool_id;
    assign req_item.address = address;
    assign req_item.size    = alloc_size;

    assign in_stall = busy;
    assign out_free = !out_valid_reg || !out_stall;

    rat_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_item  (req_item),
        .busy      (busy),
        .out_free  (out_free),
        .rd_row    (rd_row),
        .mem_req   (mem_req),
        .fin_fire  (fin_fire),
        .result    (result)
    );

    rat_mem u_mem
    (
        .clk    (clk),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign found_size  = out_reg.found_size;
    assign global_flag = out_reg.global_flag;
    assign ref_count   = out_reg.ref_count;

endmodule
